>>> rtl/aes_ke_pkg.sv
package aes_ke_pkg;

  localparam int KeyW   = 128;
  localparam int HalfW  = KeyW / 2;
  localparam int ByteW  = 8;
  localparam int RoundW = 4;
  // round index, both key halves, zero padding up to whole bytes
  localparam int OutW   = ((RoundW + KeyW + ByteW - 1) / ByteW) * ByteW;

  localparam logic [RoundW-1:0] RoundsRst = 4'd10;
  localparam logic [ByteW-1:0]  RconInit  = 8'h01;

  // Multiply by x in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [ByteW-1:0] xtime(input logic [ByteW-1:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // AES S-box: inverse in GF(2^8) followed by the affine map
  function automatic logic [ByteW-1:0] sbox(input logic [ByteW-1:0] x);
    logic [255:0][7:0] tbl;
    tbl = {
      8'h16,8'hbb,8'h54,8'hb0,8'h0f,8'h2d,8'h99,8'h41,8'h68,8'h42,8'he6,8'hbf,8'h0d,8'h89,8'ha1,8'h8c,
      8'hdf,8'h28,8'h55,8'hce,8'he9,8'h87,8'h1e,8'h9b,8'h94,8'h8e,8'hd9,8'h69,8'h11,8'h98,8'hf8,8'he1,
      8'h9e,8'h1d,8'hc1,8'h86,8'hb9,8'h57,8'h35,8'h61,8'h0e,8'hf6,8'h03,8'h48,8'h66,8'hb5,8'h3e,8'h70,
      8'h8a,8'h8b,8'hbd,8'h4b,8'h1f,8'h74,8'hdd,8'he8,8'hc6,8'hb4,8'ha6,8'h1c,8'h2e,8'h25,8'h78,8'hba,
      8'h08,8'hae,8'h7a,8'h65,8'hea,8'hf4,8'h56,8'h6c,8'ha9,8'h4e,8'hd5,8'h8d,8'h6d,8'h37,8'hc8,8'he7,
      8'h79,8'he4,8'h95,8'h91,8'h62,8'hac,8'hd3,8'hc2,8'h5c,8'h24,8'h06,8'h49,8'h0a,8'h3a,8'h32,8'he0,
      8'hdb,8'h0b,8'h5e,8'hde,8'h14,8'hb8,8'hee,8'h46,8'h88,8'h90,8'h2a,8'h22,8'hdc,8'h4f,8'h81,8'h60,
      8'h73,8'h19,8'h5d,8'h64,8'h3d,8'h7e,8'ha7,8'hc4,8'h17,8'h44,8'h97,8'h5f,8'hec,8'h13,8'h0c,8'hcd,
      8'hd2,8'hf3,8'hff,8'h10,8'h21,8'hda,8'hb6,8'hbc,8'hf5,8'h38,8'h9d,8'h92,8'h8f,8'h40,8'ha3,8'h51,
      8'ha8,8'h9f,8'h3c,8'h50,8'h7f,8'h02,8'hf9,8'h45,8'h85,8'h33,8'h4d,8'h43,8'hfb,8'haa,8'hef,8'hd0,
      8'hcf,8'h58,8'h4c,8'h4a,8'h39,8'hbe,8'hcb,8'h6a,8'h5b,8'hb1,8'hfc,8'h20,8'hed,8'h00,8'hd1,8'h53,
      8'h84,8'h2f,8'he3,8'h29,8'hb3,8'hd6,8'h3b,8'h52,8'ha0,8'h5a,8'h6e,8'h1b,8'h1a,8'h2c,8'h83,8'h09,
      8'h75,8'hb2,8'h27,8'heb,8'he2,8'h80,8'h12,8'h07,8'h9a,8'h05,8'h96,8'h18,8'hc3,8'h23,8'hc7,8'h04,
      8'h15,8'h31,8'hd8,8'h71,8'hf1,8'he5,8'ha5,8'h34,8'hcc,8'hf7,8'h3f,8'h36,8'h26,8'h93,8'hfd,8'hb7,
      8'hc0,8'h72,8'ha4,8'h9c,8'haf,8'ha2,8'hd4,8'had,8'hf0,8'h47,8'h59,8'hfa,8'h7d,8'hc9,8'h82,8'hca,
      8'h76,8'hab,8'hd7,8'hfe,8'h2b,8'h67,8'h01,8'h30,8'hc5,8'h6f,8'h6b,8'hf2,8'h7b,8'h77,8'h7c,
      8'h63};
    sbox = tbl[x];
  endfunction

endpackage

>>> rtl/aes_ke_round.sv
// One round step, one byte a cycle while step is high: the key rotates through a byte-wide
// shift line; each step one new byte enters, formed from the byte four
// places back (left neighbour word) or from the S-box of the last word.
// Sixteen steps turn the window into the next round key.
module aes_ke_round (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [aes_ke_pkg::KeyW-1:0]  key_in,
  input  logic [aes_ke_pkg::ByteW-1:0] rcon,
  output logic [aes_ke_pkg::KeyW-1:0]  key_out
);
  import aes_ke_pkg::*;

  logic [KeyW-1:0]  key_r, key_nxt;
  logic [31:0]      old_r;
  logic [3:0]       pos_r;
  logic [1:0]       sh_sel;
  logic [ByteW-1:0] sb_in, sb_out, nb;

  // byte 0 of the sliding window is at the top; new bytes enter at the bottom
  always_comb begin
    // rotated word: position p takes byte (p+1) mod 4 of the old last word
    sh_sel  = 2'd2 - pos_r[1:0];
    sb_in   = old_r[{sh_sel, 3'b000} +: ByteW];
    sb_out  = sbox(sb_in);
    if (pos_r[3:2] == 2'd0)
      nb = key_r[KeyW-1 -: ByteW] ^ sb_out ^ ((pos_r[1:0] == 2'd0) ? rcon : 8'h00);
    else
      nb = key_r[KeyW-1 -: ByteW] ^ key_r[31:24];
    key_nxt = {key_r[KeyW-ByteW-1:0], nb};
  end

  // hold a copy of the last word while the window shifts; refresh it per round
  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key_in;
      old_r <= key_in[31:0];
      pos_r <= 4'd0;
    end else if (step) begin
      key_r <= key_nxt;
      pos_r <= pos_r + 4'd1;
      if (pos_r == 4'd15) old_r <= key_nxt[31:0];
    end
  end

  assign key_out = key_r;
endmodule

>>> rtl/aes128_key_expansion.sv
// AES-128 forward key schedule. A key transfer produces num_rounds+1 round
// keys, the input key first, the last marked with out_tlast. Round keys are
// derived one byte per cycle through a byte-serial round unit with a single
// S-box, and each round key is derived in full before it is offered.
// Per key transfer the block takes the key, then offers each round key and
// derives the next after it is accepted; a stalled output holds the offer.
// A new key is taken once the last round key has been transferred. The
// round count is sampled when the key is taken.
module aes128_key_expansion (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aes_ke_pkg::RoundW-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // key_high[63:0], key_low[127:64]
  input  logic [aes_ke_pkg::KeyW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // round_index[3:0], subkey_high[67:4], subkey_low[131:68], zero pad[135:132]
  output logic [aes_ke_pkg::OutW-1:0]   out_tdata,
  output logic                          out_tlast   // final round key flag
);
  import aes_ke_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_OUT, S_RUN} state_t;

  state_t            state_r;
  logic [RoundW-1:0] rounds_r, nr_r, idx_r;
  logic [ByteW-1:0]  rc_r;
  logic [3:0]        cnt_r;
  logic              ld, stp;
  logic [KeyW-1:0]   ru_out;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (idx_r == nr_r);
  assign out_tdata  = {{(OutW - KeyW - RoundW){1'b0}}, ru_out[HalfW-1:0],
                       ru_out[KeyW-1:HalfW], idx_r};
  assign ld  = in_tvalid && in_tready;
  assign stp = (state_r == S_RUN);

  aes_ke_round u_round (
    .clk(clk), .load(ld), .step(stp),
    .key_in({in_tdata[HalfW-1:0], in_tdata[KeyW-1:HalfW]}), .rcon(rc_r), .key_out(ru_out)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) rounds_r <= RoundsRst;
    else if (cfg_we) rounds_r <= cfg_wdata;
  end

  // sequence: show a key, then derive the next in the round unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nr_r <= RoundsRst; idx_r <= '0; rc_r <= RconInit; cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          nr_r    <= rounds_r;
          idx_r   <= '0;
          rc_r    <= RconInit;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          if (idx_r == nr_r) state_r <= S_IDLE;
          else begin
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            idx_r   <= idx_r + 4'd1;
            rc_r    <= xtime(rc_r);
            state_r <= S_OUT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("both sides busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready) else $error("no return to idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == S_RUN) |-> out_tvalid) else $error("run ended elsewhere");
endmodule

>>> bench/aes_key_checker.sv
`timescale 1ns / 100ps

// Watches the key, result and register ports, predicts every round key of
// each key transfer and compares the results in order.
module aes_key_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           keys_seen,
  output int           round_keys_checked,
  output int           round_keys_pending
);

  typedef struct packed {
    logic [3:0]  round_index;
    logic [63:0] subkey_high;
    logic [63:0] subkey_low;
    logic        final_flag;
  } round_key_t;

  round_key_t  round_key_q[$];
  logic [3:0]  rounds_cfg;

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= aa;
      aa = {aa[6:0], 1'b0} ^ (aa[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // Inverse as x^254 (zero stays zero), then the affine map
  function automatic logic [7:0] subst_byte(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] pw;
    inv = 8'h01;
    pw  = x;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) inv = gf_mult(inv, pw);
      pw = gf_mult(pw, pw);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Build the whole schedule of one key and queue it
  task automatic expand_key(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [3:0] nrounds);
    logic [31:0] w [4];
    logic [31:0] rot;
    logic [31:0] t;
    logic [7:0]  rcon;
    round_key_t  rk;
    w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
    rcon = 8'h01;
    for (int r = 0; r <= nrounds; r++) begin
      if (r > 0) begin
        rot = {w[3][23:0], w[3][31:24]};
        t = {subst_byte(rot[31:24]), subst_byte(rot[23:16]),
             subst_byte(rot[15:8]), subst_byte(rot[7:0])} ^ {rcon, 24'h0};
        w[0] ^= t;
        w[1] ^= w[0];
        w[2] ^= w[1];
        w[3] ^= w[2];
        rcon = gf_mult(rcon, 8'h02);
      end
      rk.round_index = r[3:0];
      rk.subkey_high = {w[0], w[1]};
      rk.subkey_low  = {w[2], w[3]};
      rk.final_flag  = (r == nrounds);
      round_key_q = {round_key_q, rk};
    end
  endtask

  always @(posedge clk) begin
    round_key_t want;
    if (!rst_n) begin
      rounds_cfg <= 4'd10;
      round_key_q.delete();
      fail_count <= 0;
      keys_seen <= 0;
      round_keys_checked <= 0;
    end else begin
      // compare a result transfer with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (round_key_q.size() == 0) begin
          $error("round key transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = round_key_q.pop_front();
          round_keys_checked <= round_keys_checked + 1;
          if (out_tdata[3:0] !== want.round_index ||
              out_tdata[67:4] !== want.subkey_high ||
              out_tdata[131:68] !== want.subkey_low ||
              out_tlast !== want.final_flag) begin
            fail_count <= fail_count + 1;
            if (out_tdata[3:0] !== want.round_index)
              $error("round_index: expected %0d, got %0d", want.round_index, out_tdata[3:0]);
            if (out_tdata[67:4] !== want.subkey_high)
              $error("subkey_high: expected %h, got %h", want.subkey_high, out_tdata[67:4]);
            if (out_tdata[131:68] !== want.subkey_low)
              $error("subkey_low: expected %h, got %h", want.subkey_low, out_tdata[131:68]);
            if (out_tlast !== want.final_flag)
              $error("tlast: expected %0d, got %0d", want.final_flag, out_tlast);
          end
        end
      end
      // track the round count register
      if (cfg_we) rounds_cfg <= cfg_wdata;
      // predict on each key transfer
      if (in_tvalid && in_tready) begin
        expand_key(in_tdata[63:0], in_tdata[127:64], rounds_cfg);
        keys_seen <= keys_seen + 1;
      end
    end
    round_keys_pending <= round_key_q.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 1000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tlast;

  int fail_count;
  int keys_seen;
  int round_keys_checked;
  int round_keys_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  aes128_key_expansion dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  aes_key_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .fail_count        (fail_count),
    .keys_seen         (keys_seen),
    .round_keys_checked(round_keys_checked),
    .round_keys_pending(round_keys_pending)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one key, idling first at random; valid stays high for back-to-back keys
  task automatic send_key(input logic [63:0] kh, input logic [63:0] kl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {kl, kh};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drain the block, then write the round count
  task automatic set_rounds(input logic [3:0] nrounds);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (round_keys_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nrounds;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_keys(input int count);
    for (int i = 0; i < count; i++)
      send_key({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset round count, edge keys and the standard test key
    send_key(64'h0, 64'h0);
    send_key({64{1'b1}}, {64{1'b1}});
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    // zero rounds: the key alone, marked last
    set_rounds(4'd0);
    send_key(64'h8000000000000000, 64'h1);
    send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    // longest schedule, round constant past the tenth round
    set_rounds(4'd15);
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_key(64'h0, 64'h0);
    send_key({64{1'b1}}, 64'h0);
    set_rounds(4'd1);
    send_key(64'h0123456789abcdef, 64'hfedcba9876543210);
    send_key(64'h1, 64'h8000000000000000);

    // Random keys across idling phases and round counts
    send_idle_pct = 0;  recv_stall_pct = 0;
    set_rounds(4'($urandom_range(15)));
    send_random_keys(40);
    set_rounds(4'd10);
    send_random_keys(40);
    send_idle_pct = 80; recv_stall_pct = 0;
    set_rounds(4'($urandom_range(15)));
    send_random_keys(40);
    set_rounds(4'd0);
    send_random_keys(40);
    send_idle_pct = 0;  recv_stall_pct = 80;
    set_rounds(4'd15);
    send_random_keys(40);
    set_rounds(4'($urandom_range(15)));
    send_random_keys(40);
    send_idle_pct = 13; recv_stall_pct = 13;
    set_rounds(4'($urandom_range(15)));
    send_random_keys(40);
    send_idle_pct = 0;  recv_stall_pct = 0;
    set_rounds(4'($urandom_range(15)));
    send_random_keys(37);
    in_tvalid <= 1'b0;

    // Drain and settle
    @(posedge clk);
    while (round_keys_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb: %0d keys expanded, %0d round keys compared, round counts 0, 1, 10, 15 and random",
             keys_seen, round_keys_checked);
    $display("tb: idling phases none, sender 80%%, receiver 80%%, both 13%%");
    if (fail_count == 0 && round_keys_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
